/* rtl/core/wcic_pkg.sv */
package wcic_pkg;

  localparam int TAPS      = 3;
  localparam int NCOEF     = 8;
  localparam int SAMPLE_W  = 24;
  localparam int COEF_W    = 16;
  localparam int CFG_IDX_W = 3;
  localparam int PROD_W    = SAMPLE_W + COEF_W;
  localparam int SUM_W     = 42;
  // one bit of headroom: the exact sum stays within [-2^41, 2^41]
  localparam int ACC_W     = SUM_W + 1;
  localparam int COUNT_W   = 32;

  localparam int HIST_N     = (TAPS > 1) ? TAPS - 1 : 1;
  localparam int HIST_IDX_W = (HIST_N > 1) ? $clog2(HIST_N) : 1;
  localparam int FILL_W     = (TAPS > 1) ? $clog2(TAPS) : 1;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [ACC_W-1:0]    acc_t;
  typedef logic signed [SUM_W-1:0]    sum_t;
  typedef logic [COUNT_W-1:0]         count_t;
  typedef logic [CFG_IDX_W-1:0]       cfg_idx_t;

  typedef coef_t   [NCOEF-1:0] coef_bank_t;
  typedef sample_t [TAPS-1:0]  window_t;
  typedef prod_t   [TAPS-1:0]  prod_vec_t;

endpackage

/* rtl/core/wcic_sample_if.sv */
interface wcic_sample_if;
  logic              valid;
  logic              ready;
  wcic_pkg::sample_t sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

/* rtl/core/wcic_result_if.sv */
interface wcic_result_if;
  logic             valid;
  logic             ready;
  wcic_pkg::sum_t   window_sum;
  wcic_pkg::count_t increase_count;

  modport source (output valid, output window_sum, output increase_count, input ready);
  modport sink (input valid, input window_sum, input increase_count, output ready);
endinterface

/* rtl/core/wcic_cfg.sv */
module wcic_cfg (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  wcic_pkg::cfg_idx_t    cfg_index,
  input  wcic_pkg::coef_t       cfg_data,
  output wcic_pkg::coef_bank_t  coefs
);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < wcic_pkg::NCOEF; k++) begin
        coefs[k] <= wcic_pkg::coef_t'(1);
      end
    end else if (cfg_we) begin
      coefs[cfg_index] <= cfg_data;
    end
  end

endmodule

/* rtl/core/wcic_window.sv */
module wcic_window (
  input  logic                clk,
  input  logic                rst,
  wcic_sample_if.sink         smp,
  output logic                win_valid,
  output wcic_pkg::window_t   win,
  input  logic                win_ready
);

  logic                        take;
  logic                        full;
  logic [wcic_pkg::FILL_W-1:0] fill;
  wcic_pkg::window_t           win_next;

  assign smp.ready = !win_valid || win_ready;
  assign take      = smp.valid && smp.ready;
  assign full      = (fill == wcic_pkg::FILL_W'(wcic_pkg::TAPS - 1));

  if (wcic_pkg::TAPS > 1) begin : g_hist
    wcic_pkg::sample_t hist [wcic_pkg::HIST_N];

    always_ff @(posedge clk) begin
      if (take) begin
        if (full) begin
          for (int k = 0; k < wcic_pkg::HIST_N - 1; k++) begin
            hist[k] <= hist[k+1];
          end
          hist[wcic_pkg::HIST_N-1] <= smp.sample;
        end else begin
          hist[fill[wcic_pkg::HIST_IDX_W-1:0]] <= smp.sample;
        end
      end
    end

    always_comb begin
      for (int k = 0; k < wcic_pkg::TAPS - 1; k++) begin
        win_next[k] = hist[k];
      end
      win_next[wcic_pkg::TAPS-1] = smp.sample;
    end
  end else begin : g_single
    assign win_next[0] = smp.sample;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      win_valid <= 1'b0;
    end else begin
      if (take && !full) begin
        fill <= fill + wcic_pkg::FILL_W'(1);
      end
      if (smp.ready) begin
        win_valid <= take && full;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && full) begin
      win <= win_next;
    end
  end

endmodule

/* rtl/core/wcic_mac.sv */
module wcic_mac (
  input  logic                  clk,
  input  logic                  rst,
  input  wcic_pkg::coef_bank_t  coefs,
  input  logic                  win_valid,
  input  wcic_pkg::window_t     win,
  output logic                  win_ready,
  output logic                  sum_valid,
  output wcic_pkg::sum_t        sum,
  input  logic                  sum_ready
);

  logic                  prod_valid;
  logic                  prod_ready;
  wcic_pkg::prod_vec_t   prods;
  wcic_pkg::prod_vec_t   prods_next;
  wcic_pkg::acc_t        acc;
  wcic_pkg::sum_t        sum_next;

  assign prod_ready = !sum_valid || sum_ready;
  assign win_ready  = !prod_valid || prod_ready;

  always_comb begin
    for (int k = 0; k < wcic_pkg::TAPS; k++) begin
      prods_next[k] = wcic_pkg::prod_t'($signed(win[k])) *
                      wcic_pkg::prod_t'($signed(coefs[k]));
    end
  end

  always_comb begin
    acc = '0;
    for (int k = 0; k < wcic_pkg::TAPS; k++) begin
      acc = acc + wcic_pkg::acc_t'($signed(prods[k]));
    end
    // only +2^41 can overflow; the top two bits disagree exactly then
    if (acc[wcic_pkg::ACC_W-1] != acc[wcic_pkg::SUM_W-1]) begin
      sum_next = acc[wcic_pkg::ACC_W-1] ? {1'b1, {(wcic_pkg::SUM_W-1){1'b0}}}
                                        : {1'b0, {(wcic_pkg::SUM_W-1){1'b1}}};
    end else begin
      sum_next = acc[wcic_pkg::SUM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      sum_valid  <= 1'b0;
    end else begin
      if (win_ready) begin
        prod_valid <= win_valid;
      end
      if (prod_ready) begin
        sum_valid <= prod_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (win_ready && win_valid) begin
      prods <= prods_next;
    end
    if (prod_ready && prod_valid) begin
      sum <= sum_next;
    end
  end

endmodule

/* rtl/core/wcic_count.sv */
module wcic_count (
  input  logic            clk,
  input  logic            rst,
  input  logic            sum_valid,
  input  wcic_pkg::sum_t  sum,
  output logic            sum_ready,
  wcic_result_if.source   res
);

  logic             take;
  logic             have_prev;
  logic             bump;
  wcic_pkg::sum_t   prev_sum;
  wcic_pkg::count_t count;
  wcic_pkg::count_t count_next;

  assign sum_ready  = !res.valid || res.ready;
  assign take       = sum_valid && sum_ready;
  assign bump       = have_prev && (sum > prev_sum) && (count != '1);
  assign count_next = bump ? count + wcic_pkg::count_t'(1) : count;

  always_ff @(posedge clk) begin
    if (rst) begin
      have_prev <= 1'b0;
      count     <= '0;
      res.valid <= 1'b0;
    end else begin
      if (take) begin
        have_prev <= 1'b1;
        count     <= count_next;
      end
      if (sum_ready) begin
        res.valid <= sum_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      prev_sum           <= sum;
      res.window_sum     <= sum;
      res.increase_count <= count_next;
    end
  end

endmodule

/* rtl/core/window_correlator_increase_count_core.sv */
// channel  dir  handshake          payload
// smp      in   valid/ready        sample (24b signed)
// res      out  valid/ready        window_sum (42b signed), increase_count (32b)
// cfg      in   cfg_we, no ready   cfg_index (3b), cfg_data (16b coef)
//
// One sample per cycle sustained while res is not stalled; the four-stage
// pipeline (window register, multipliers, adder tree with saturation,
// compare/count register) registers each accepted sample's result on res.
// The first TAPS-1 samples after reset only fill the history and give no result.
// Synchronous reset clears the history fill, the count and all valid bits;
// coefficients reset to 1. A stall on res backs up stage by stage, so
// requests keep being taken while any stage holds a bubble.
module window_correlator_increase_count_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  wcic_pkg::cfg_idx_t cfg_index,
  input  wcic_pkg::coef_t    cfg_data,
  wcic_sample_if.sink        smp,
  wcic_result_if.source      res
);

  wcic_pkg::coef_bank_t coefs;
  logic                 win_valid;
  logic                 win_ready;
  wcic_pkg::window_t    win;
  logic                 sum_valid;
  logic                 sum_ready;
  wcic_pkg::sum_t       sum;

  wcic_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .coefs     (coefs)
  );

  wcic_window u_window (
    .clk       (clk),
    .rst       (rst),
    .smp       (smp),
    .win_valid (win_valid),
    .win       (win),
    .win_ready (win_ready)
  );

  wcic_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .coefs     (coefs),
    .win_valid (win_valid),
    .win       (win),
    .win_ready (win_ready),
    .sum_valid (sum_valid),
    .sum       (sum),
    .sum_ready (sum_ready)
  );

  wcic_count u_count (
    .clk       (clk),
    .rst       (rst),
    .sum_valid (sum_valid),
    .sum       (sum),
    .sum_ready (sum_ready),
    .res       (res)
  );

endmodule
